>>> design/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   parameter int MAX_DST_WIDTH = 1024;
   parameter int MAX_SRC_DIM   = 4096;

   // Widths of sizes (which must hold the limit itself) and of positions.
   localparam int DIM_W  = $clog2(MAX_SRC_DIM) + 1;
   localparam int DW_W   = $clog2(MAX_DST_WIDTH) + 1;
   localparam int COL_W  = $clog2(MAX_DST_WIDTH);
   localparam int ROW_W  = $clog2(MAX_SRC_DIM);
   localparam int SUM_W  = 32;
   localparam int CNT_W  = 2 * DIM_W;
   localparam int LANES  = 4;
   localparam int PIX_W  = 8;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_HAS_ALPHA  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
      logic [PIX_W-1:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic [PIX_W-1:0] out_alpha;
      logic [COL_W-1:0] out_col;
      logic [ROW_W-1:0] out_row;
      logic             frame_last;
   } rsp_type;

   // Frame geometry: clamped sizes and the base box step with its remainder.
   typedef struct packed {
      logic [DIM_W-1:0] eff_w;
      logic [DIM_W-1:0] eff_h;
      logic [DW_W-1:0]  eff_dw;
      logic [DIM_W-1:0] eff_dh;
      logic [DIM_W-1:0] qw;
      logic [DIM_W-1:0] rw;
      logic [DIM_W-1:0] qh;
      logic [DIM_W-1:0] rh;
   } geo_type;

   typedef logic [LANES-1:0][SUM_W-1:0] sum_vec_type;
   typedef logic [LANES-1:0][PIX_W-1:0] pix_vec_type;

endpackage

`default_nettype wire

>>> design/bfd_line_ram.sv
// ----------------------------------------------------------------------------
// bfd_line_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/bfd_geom.sv
// ----------------------------------------------------------------------------
// bfd_geom
// Clamps the configured sizes and works out the base box steps by two
// bit-serial restoring divisions, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_geom import bfd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIM_W-1:0] src_width,
   input  wire logic [DIM_W-1:0] src_height,
   input  wire logic [DW_W-1:0]  dst_width,
   input  wire logic [DIM_W-1:0] dst_height,
   output geo_type               geo,
   output logic                  done
);

   localparam int STEP_W = $clog2(DIM_W);

   logic [DIM_W-1:0]  ew, eh, dwmax, dh;
   logic [DW_W-1:0]   dw;
   geo_type           geo_ff;
   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIM_W:0]    remw_ff, remh_ff, remw_sh, remh_sh;

   always_comb begin
      if (src_width == '0) ew = DIM_W'(1);
      else if (src_width > DIM_W'(MAX_SRC_DIM)) ew = DIM_W'(MAX_SRC_DIM);
      else ew = src_width;
      if (src_height == '0) eh = DIM_W'(1);
      else if (src_height > DIM_W'(MAX_SRC_DIM)) eh = DIM_W'(MAX_SRC_DIM);
      else eh = src_height;
      dwmax = (ew < DIM_W'(MAX_DST_WIDTH)) ? ew : DIM_W'(MAX_DST_WIDTH);
      if (dst_width == '0) dw = DW_W'(1);
      else if (DIM_W'(dst_width) > dwmax) dw = DW_W'(dwmax);
      else dw = dst_width;
      if (dst_height == '0) dh = DIM_W'(1);
      else if (dst_height > eh) dh = eh;
      else dh = dst_height;
   end

   assign remw_sh = {remw_ff[DIM_W-1:0], geo_ff.eff_w[step_ff]};
   assign remh_sh = {remh_ff[DIM_W-1:0], geo_ff.eff_h[step_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         geo_ff.eff_w  <= ew;
         geo_ff.eff_h  <= eh;
         geo_ff.eff_dw <= dw;
         geo_ff.eff_dh <= dh;
         geo_ff.qw     <= '0;
         geo_ff.qh     <= '0;
         geo_ff.rw     <= '0;
         geo_ff.rh     <= '0;
         remw_ff       <= '0;
         remh_ff       <= '0;
         step_ff       <= STEP_W'(DIM_W - 1);
      end else if (busy_ff) begin
         if (remw_sh >= (DIM_W+1)'(geo_ff.eff_dw)) begin
            remw_ff <= remw_sh - (DIM_W+1)'(geo_ff.eff_dw);
            geo_ff.qw[step_ff] <= 1'b1;
         end else begin
            remw_ff <= remw_sh;
         end
         if (remh_sh >= {1'b0, geo_ff.eff_dh}) begin
            remh_ff <= remh_sh - {1'b0, geo_ff.eff_dh};
            geo_ff.qh[step_ff] <= 1'b1;
         end else begin
            remh_ff <= remh_sh;
         end
         if (step_ff != '0) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   always_comb begin
      geo    = geo_ff;
      geo.rw = remw_ff[DIM_W-1:0];
      geo.rh = remh_ff[DIM_W-1:0];
   end

   assign done = done_ff;

endmodule

`default_nettype wire

>>> design/bfd_mean_div.sv
// ----------------------------------------------------------------------------
// bfd_mean_div
// Four-lane restoring divider for the box means. A mean never exceeds 255,
// so eight quotient bits, one per cycle, are enough.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_mean_div import bfd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire sum_vec_type      sums,
   input  wire logic [CNT_W-1:0] cnt,
   output pix_vec_type           quot,
   output logic                  done
);

   localparam int REM_W  = SUM_W + 1;
   localparam int STEP_W = $clog2(PIX_W);

   logic [LANES-1:0][REM_W-1:0] rem_ff;
   logic [REM_W-1:0]            dv_ff;
   pix_vec_type                 quot_ff;
   logic [STEP_W-1:0]           step_ff;
   logic                        busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dv_ff   <= REM_W'({cnt, {(PIX_W-1){1'b0}}});
         quot_ff <= '0;
         step_ff <= STEP_W'(PIX_W - 1);
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= {1'b0, sums[i]};
         end
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            if (rem_ff[i] >= dv_ff) begin
               rem_ff[i]           <= rem_ff[i] - dv_ff;
               quot_ff[i][step_ff] <= 1'b1;
            end
         end
         dv_ff <= dv_ff >> 1;
         if (step_ff != '0) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> design/box_filter_image_downscaler.sv
// ----------------------------------------------------------------------------
// box_filter_image_downscaler
// Area-average downscaler: per-column box sums live in a line RAM that is
// read, updated and written back for every source pixel.
// ----------------------------------------------------------------------------
//  Port group  Direction  Contents
//  req_        in         one source pixel (R, G, B, A) in raster order
//  rsp_        out        one target pixel with its column, row and frame end
//  csr_        in         register writes: sizes and alpha mode
//
//  A source pixel is read from the RAM, then updated and written back in the
//  update state. A pixel that closes a box then waits in the divide state for
//  the eight quotient bits and the done pulse, and passes through the output
//  state for the transfer into the output register.
//  After reset and after each write to a known register the geometry dividers
//  run, during which req_stall is high.
//  The output register holds one result; the next box result waits in ST_HOLD.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_image_downscaler import bfd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata
);

   typedef enum logic [5:0] {
      ST_GEOM = 6'b000001,
      ST_IDLE = 6'b000010,
      ST_MOD  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_OUT  = 6'b010000,
      ST_HOLD = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] src_width_ff, src_height_ff, dst_height_ff;
   logic [DW_W-1:0]  dst_width_ff;
   logic             has_alpha_ff, geo_start_ff, csr_hit;
   geo_type          geo;
   logic             geo_done, geo_ready;

   logic [ROW_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [COL_W-1:0] box_col_ff, box_col_in;
   logic [ROW_W-1:0] box_row_ff, box_row_in;
   logic [DIM_W-1:0] col_start_ff, col_start_in, col_end_ff, col_end_in;
   logic [DIM_W-1:0] row_start_ff, row_start_in, row_end_ff, row_end_in;
   logic [DIM_W-1:0] col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;

   logic             accept, col_done, row_done, line_end, frame_end, first_px;
   logic [DIM_W:0]   col_next, row_next, col_sum, row_sum;

   req_type          pix_ff;
   logic             first_ff, emit_ff, last_ff;
   logic [COL_W-1:0] k_ff;
   logic [ROW_W-1:0] orow_ff;
   logic [DIM_W-1:0] fw_ff, fh_ff;

   sum_vec_type      rd_sums, new_sums;
   pix_vec_type      pix_vec, quot;
   logic             div_done;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff, rsp_load;

   // Register file. A write to a known register restarts the frame.
   assign csr_hit = csr_wr_en && (csr_index == CSR_SRC_WIDTH || csr_index == CSR_SRC_HEIGHT
                    || csr_index == CSR_DST_WIDTH || csr_index == CSR_DST_HEIGHT
                    || csr_index == CSR_HAS_ALPHA);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(1);
         src_height_ff <= DIM_W'(1);
         dst_width_ff  <= DW_W'(1);
         dst_height_ff <= DIM_W'(1);
         has_alpha_ff  <= 1'b0;
         geo_start_ff  <= 1'b1;
      end else begin
         geo_start_ff <= csr_hit;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
               CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
               CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[DW_W-1:0];
               CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
               CSR_HAS_ALPHA:  has_alpha_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   bfd_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .start      (geo_start_ff),
      .src_width  (src_width_ff),
      .src_height (src_height_ff),
      .dst_width  (dst_width_ff),
      .dst_height (dst_height_ff),
      .geo        (geo),
      .done       (geo_done)
   );

   // A finish from an earlier run does not count while a new one is starting.
   assign geo_ready = geo_done && !geo_start_ff;

   // Position tracking, evaluated for the pixel being transferred in.
   assign accept    = req_valid && !req_stall;
   assign col_done  = ({1'b0, src_col_ff} + DIM_W'(1)) == col_end_ff;
   assign row_done  = ({1'b0, src_row_ff} + DIM_W'(1)) == row_end_ff;
   assign line_end  = ({1'b0, src_col_ff} + DIM_W'(1)) >= geo.eff_w;
   assign frame_end = line_end && (({1'b0, src_row_ff} + DIM_W'(1)) >= geo.eff_h);
   assign first_px  = ({1'b0, src_row_ff} == row_start_ff)
                      && ({1'b0, src_col_ff} == col_start_ff);

   assign col_sum  = {1'b0, col_rem_ff} + {1'b0, geo.rw};
   assign row_sum  = {1'b0, row_rem_ff} + {1'b0, geo.rh};
   assign col_next = (col_sum >= (DIM_W+1)'(geo.eff_dw))
                     ? col_sum - (DIM_W+1)'(geo.eff_dw) : col_sum;
   assign row_next = (row_sum >= {1'b0, geo.eff_dh}) ? row_sum - {1'b0, geo.eff_dh} : row_sum;

   always_comb begin
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      box_col_in   = box_col_ff;
      box_row_in   = box_row_ff;
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      col_rem_in   = col_rem_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      row_rem_in   = row_rem_ff;
      if ((state_ff == ST_GEOM && geo_ready) || (accept && frame_end)) begin
         src_col_in   = '0;
         src_row_in   = '0;
         box_col_in   = '0;
         box_row_in   = '0;
         col_start_in = '0;
         col_end_in   = geo.qw;
         col_rem_in   = geo.rw;
         row_start_in = '0;
         row_end_in   = geo.qh;
         row_rem_in   = geo.rh;
      end else if (accept && line_end) begin
         src_col_in   = '0;
         box_col_in   = '0;
         col_start_in = '0;
         col_end_in   = geo.qw;
         col_rem_in   = geo.rw;
         src_row_in   = src_row_ff + ROW_W'(1);
         if (row_done) begin
            row_rem_in   = row_next[DIM_W-1:0];
            row_start_in = row_end_ff;
            row_end_in   = row_end_ff + geo.qh
                           + DIM_W'(row_sum >= {1'b0, geo.eff_dh});
            box_row_in   = box_row_ff + ROW_W'(1);
         end
      end else if (accept) begin
         src_col_in = src_col_ff + ROW_W'(1);
         if (col_done) begin
            col_rem_in   = col_next[DIM_W-1:0];
            col_start_in = col_end_ff;
            col_end_in   = col_end_ff + geo.qw
                           + DIM_W'(col_sum >= (DIM_W+1)'(geo.eff_dw));
            box_col_in   = box_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      src_col_ff   <= src_col_in;
      src_row_ff   <= src_row_in;
      box_col_ff   <= box_col_in;
      box_row_ff   <= box_row_in;
      col_start_ff <= col_start_in;
      col_end_ff   <= col_end_in;
      col_rem_ff   <= col_rem_in;
      row_start_ff <= row_start_in;
      row_end_ff   <= row_end_in;
      row_rem_ff   <= row_rem_in;
      if (accept) begin
         pix_ff   <= req_data;
         first_ff <= first_px;
         emit_ff  <= col_done && row_done;
         last_ff  <= frame_end;
         k_ff     <= box_col_ff;
         orow_ff  <= box_row_ff;
         fw_ff    <= col_end_ff - col_start_ff;
         fh_ff    <= row_end_ff - row_start_ff;
      end
   end

   // Read, modify and write back the column sums. The next read is issued
   // only after the write, so no forwarding is required.
   bfd_line_ram #(
      .DEPTH (MAX_DST_WIDTH),
      .WIDTH (LANES * SUM_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_MOD),
      .wr_addr (k_ff),
      .wr_data (new_sums),
      .rd_en   (accept),
      .rd_addr (box_col_ff),
      .rd_data (rd_sums)
   );

   assign pix_vec = {pix_ff.in_red, pix_ff.in_green, pix_ff.in_blue, pix_ff.in_alpha};

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         new_sums[i] = first_ff ? SUM_W'(pix_vec[i]) : rd_sums[i] + SUM_W'(pix_vec[i]);
      end
   end

   bfd_mean_div u_mean_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_MOD && emit_ff),
      .sums  (new_sums),
      .cnt   (CNT_W'(fw_ff) * CNT_W'(fh_ff)),
      .quot  (quot),
      .done  (div_done)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_GEOM: if (geo_ready) state_in = ST_IDLE;
         ST_IDLE: if (accept) state_in = ST_MOD;
         ST_MOD:  state_in = emit_ff ? ST_DIV : ST_IDLE;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  state_in = rsp_load ? ST_IDLE : ST_HOLD;
         ST_HOLD: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_GEOM;
      endcase
      if (csr_hit) begin
         state_in = ST_GEOM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GEOM;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Output register: loads a finished box result when it is empty or when its result is transferred.
   assign rsp_load = (state_ff == ST_OUT || state_ff == ST_HOLD)
                     && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.out_red    <= quot[3];
         rsp_ff.out_green  <= quot[2];
         rsp_ff.out_blue   <= quot[1];
         rsp_ff.out_alpha  <= has_alpha_ff ? quot[0] : PIX_W'(255);
         rsp_ff.out_col    <= k_ff;
         rsp_ff.out_row    <= orow_ff;
         rsp_ff.frame_last <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   property p_accept_to_update;
      @(posedge clock) disable iff (reset) accept && !csr_hit |=> state_ff == ST_MOD;
   endproperty
   a_accept_to_update: assert property (p_accept_to_update)
      else $error("pixel transfer not followed by the update cycle");

   property p_div_only_when_waiting;
      @(posedge clock) disable iff (reset) div_done |-> state_ff == ST_DIV;
   endproperty
   a_div_only_when_waiting: assert property (p_div_only_when_waiting)
      else $error("mean divider finished outside the divide state");

   property p_rsp_from_box;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT || $past(state_ff) == ST_HOLD);
   endproperty
   a_rsp_from_box: assert property (p_rsp_from_box)
      else $error("result appeared without a finished box");

   property p_box_col_range;
      @(posedge clock) disable iff (reset)
         state_ff == ST_IDLE |-> DW_W'(box_col_ff) < geo.eff_dw;
   endproperty
   a_box_col_range: assert property (p_box_col_range)
      else $error("box column beyond the target width");

endmodule

`default_nettype wire
